// ===== sv/cfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants for the command frame builder
// Field codes, header bits, CRC-16 constants and the sequencer state type.
// ----------------------------------------------------------------------------
package cfb_pkg;

    // Request kind
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Target group codes
    localparam logic [1:0] TG_SINGLE   = 2'd0;
    localparam logic [1:0] TG_RESERVED = 2'd3;

    // Header bits
    localparam logic [7:0] HDR_BASE  = 8'h80;
    localparam logic [7:0] HDR_WRITE = 8'h10;

    // Largest read count code (read count minus one)
    localparam logic [7:0] READ_MAX_CODE = 8'd127;

    // CRC-16, reflected, no final xor
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR,
        ST_DEV,
        ST_ADDR_HI,
        ST_ADDR_LO,
        ST_DATA,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_REJECT
    } cfb_state_t;

    // Control from the sequencer to the CRC unit
    typedef struct packed {
        logic init;    // restart at CRC_INIT
        logic update;  // fold one byte into the CRC
    } cfb_crc_ctrl_t;

endpackage

// ===== sv/command_frame_builder_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_builder_crc16: daisy-chain command frame builder
// Turns one request into a command frame ending in a CRC-16, one byte per beat.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. A valid request produces
// its frame (header, device id for single-device frames, address high and
// low, payload or read count code, CRC low and high) at one byte per cycle
// while the output is not stalled, with tlast on the final CRC byte; a frame
// is 6 to 14 bytes long. The byte sequencer drives the CRC unit, which folds
// in one byte per cycle while the output advances. An invalid request (bad
// length, bad read count, reserved group) yields one beat with data zero,
// tlast and the rejected flag. Output back-pressure stalls both beat for beat.
module command_frame_builder_crc16
#(
    parameter int MAX_PAYLOAD_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: device_id[7:0], register_address[23:8], write_data[87:24],
    //          data_length[91:88], read_count[99:92], zero[103:100]
    input  logic [103:0] s_tdata,
    // s_tuser: mode[0], target_group[2:1]
    input  logic [2:0]   s_tuser,
    // Frame byte channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: frame_byte[7:0]
    output logic [7:0]   m_tdata,
    output logic         m_tlast,
    // m_tuser: rejected[0]
    output logic [0:0]   m_tuser
);
    import cfb_pkg::*;

    localparam int PAY_W = MAX_PAYLOAD_BYTES * 8;
    localparam int IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

    // Request fields
    logic        in_mode;
    logic [1:0]  in_group;
    logic [7:0]  in_dev;
    logic [15:0] in_addr;
    logic [63:0] in_wdata;
    logic [3:0]  in_len;
    logic [7:0]  in_rcount;
    logic        req_ok;
    logic        accept;
    logic        advance;

    assign in_mode   = s_tuser[0];
    assign in_group  = s_tuser[2:1];
    assign in_dev    = s_tdata[7:0];
    assign in_addr   = s_tdata[23:8];
    assign in_wdata  = s_tdata[87:24];
    assign in_len    = s_tdata[91:88];
    assign in_rcount = s_tdata[99:92];

    // Request check
    always_comb
    begin
        if (in_group == TG_RESERVED)
            req_ok = 1'b0;
        else if (in_mode == MODE_WRITE)
            req_ok = (in_len != 4'd0) && ({28'd0, in_len} <= 32'(MAX_PAYLOAD_BYTES));
        else
            req_ok = (in_rcount != 8'd0) && ((in_rcount - 8'd1) <= READ_MAX_CODE);
    end

    // Registers
    cfb_state_t        state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [1:0]        group_reg, group_next;
    logic [7:0]        dev_reg, dev_next;
    logic [15:0]       addr_reg, addr_next;
    logic [PAY_W-1:0]  payload_reg, payload_next;
    logic [IDX_W-1:0]  data_cnt_reg, data_cnt_next;
    logic [7:0]        read_code_reg, read_code_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              m_tuser_reg, m_tuser_next;

    // Sequencer outputs
    logic [7:0]        byte_sel;
    logic              last_sel;
    logic              rej_sel;
    cfb_crc_ctrl_t     crc_ctrl;
    logic [15:0]       crc;
    logic [7:0]        hdr_byte;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign advance  = (state_reg != ST_IDLE) && (!m_tvalid_reg || m_tready);

    assign hdr_byte = HDR_BASE | {1'b0, group_reg, 5'b00000}
                    | ((mode_reg == MODE_WRITE)
                       ? (HDR_WRITE | {{(8-IDX_W){1'b0}}, data_cnt_reg}) : 8'h00);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = req_ok ? ST_HDR : ST_REJECT;
            end
            ST_HDR:
            begin
                if (advance)
                    state_next = (group_reg == TG_SINGLE) ? ST_DEV : ST_ADDR_HI;
            end
            ST_DEV:
            begin
                if (advance)
                    state_next = ST_ADDR_HI;
            end
            ST_ADDR_HI:
            begin
                if (advance)
                    state_next = ST_ADDR_LO;
            end
            ST_ADDR_LO:
            begin
                if (advance)
                    state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (advance && (mode_reg == MODE_READ || data_cnt_reg == '0))
                    state_next = ST_CRC_LO;
            end
            ST_CRC_LO:
            begin
                if (advance)
                    state_next = ST_CRC_HI;
            end
            ST_CRC_HI, ST_REJECT:
            begin
                if (advance)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: byte to send and CRC control
    always_comb
    begin
        byte_sel        = 8'h00;
        last_sel        = 1'b0;
        rej_sel         = 1'b0;
        crc_ctrl.init   = accept;
        crc_ctrl.update = 1'b0;
        unique case (state_reg)
            ST_HDR:
            begin
                byte_sel        = hdr_byte;
                crc_ctrl.update = advance;
            end
            ST_DEV:
            begin
                byte_sel        = dev_reg;
                crc_ctrl.update = advance;
            end
            ST_ADDR_HI:
            begin
                byte_sel        = addr_reg[15:8];
                crc_ctrl.update = advance;
            end
            ST_ADDR_LO:
            begin
                byte_sel        = addr_reg[7:0];
                crc_ctrl.update = advance;
            end
            ST_DATA:
            begin
                byte_sel        = (mode_reg == MODE_WRITE)
                                  ? payload_reg[{data_cnt_reg, 3'b000} +: 8] : read_code_reg;
                crc_ctrl.update = advance;
            end
            ST_CRC_LO:
                byte_sel = crc[7:0];
            ST_CRC_HI:
            begin
                byte_sel = crc[15:8];
                last_sel = 1'b1;
            end
            ST_REJECT:
            begin
                last_sel = 1'b1;
                rej_sel  = 1'b1;
            end
            default:
                byte_sel = 8'h00;
        endcase
    end

    // Request and payload registers
    always_comb
    begin
        mode_next      = mode_reg;
        group_next     = group_reg;
        dev_next       = dev_reg;
        addr_next      = addr_reg;
        payload_next   = payload_reg;
        data_cnt_next  = data_cnt_reg;
        read_code_next = read_code_reg;
        if (accept)
        begin
            mode_next      = in_mode;
            group_next     = in_group;
            dev_next       = in_dev;
            addr_next      = in_addr;
            payload_next   = in_wdata[PAY_W-1:0];
            data_cnt_next  = IDX_W'(in_len - 4'd1);
            read_code_next = in_rcount - 8'd1;
        end
        else if (state_reg == ST_DATA && advance && mode_reg == MODE_WRITE
                 && data_cnt_reg != '0)
        begin
            data_cnt_next = data_cnt_reg - 1'b1;
        end
    end

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (advance)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = byte_sel;
            m_tlast_next  = last_sel;
            m_tuser_next  = rej_sel;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        group_reg     <= group_next;
        dev_reg       <= dev_next;
        addr_reg      <= addr_next;
        payload_reg   <= payload_next;
        data_cnt_reg  <= data_cnt_next;
        read_code_reg <= read_code_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
        m_tuser_reg   <= m_tuser_next;
    end

    // Shared CRC unit
    cfb_crc u_crc
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (crc_ctrl),
        .data_in (byte_sel),
        .crc     (crc)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Checks
    // A rejection is a single zero beat that also closes the request
    a_reject_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == 8'h00))
        else $error("rejected beat without tlast or with nonzero data");

    // A valid request always starts with the header
    a_valid_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_ok) |=> (state_reg == ST_HDR))
        else $error("valid request did not start a frame");

    // Sending the CRC high byte ends the frame with tlast
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CRC_HI && advance) |=>
            (state_reg == ST_IDLE && m_tvalid && m_tlast && !m_tuser[0]))
        else $error("frame did not close after the CRC high byte");

    // tlast appears only on the CRC high byte or a rejection
    a_last_source: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_sel) |-> (state_reg == ST_CRC_HI || state_reg == ST_REJECT))
        else $error("tlast raised inside a frame");

endmodule

// ===== sv/cfb_crc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_crc: byte-wide CRC-16 accumulator
// Folds one frame byte per update into the running CRC register.
// ----------------------------------------------------------------------------
module cfb_crc
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfb_pkg::cfb_crc_ctrl_t ctrl,
    input  logic [7:0]            data_in,
    output logic [15:0]           crc
);
    import cfb_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_step;

    // Eight bit steps of the reflected polynomial
    always_comb
    begin
        crc_step = crc_reg ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (crc_step[0])
                crc_step = (crc_step >> 1) ^ CRC_POLY;
            else
                crc_step = crc_step >> 1;
        end
    end

    // Next CRC value
    always_comb
    begin
        priority if (ctrl.init)
            crc_next = CRC_INIT;
        else if (ctrl.update)
            crc_next = crc_step;
        else
            crc_next = crc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule
